// ===== src/bsra_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bsra_pkg;

   // Frame geometry and field widths
   localparam int PIXEL_COUNT_DEFAULT = 131072;
   localparam int IDX_W               = 17;
   localparam int PIX_W               = 8;
   localparam int BG_W                = 24;
   localparam int LANES               = 3;

   // Configuration defaults
   localparam logic [7:0] THRESHOLD_RESET = 8'd30;
   localparam logic [8:0] ALPHA_RESET     = 9'd13;
   localparam logic       SELECTIVE_RESET = 1'b1;
   localparam logic       COLOR_RESET     = 1'b0;

   // Alpha of one in Q8
   localparam logic [8:0] ALPHA_ONE = 9'd256;

   // Item operation codes
   typedef enum logic {
      OP_SEGMENT = 1'b0,
      OP_LOAD    = 1'b1
   } op_type;

   // Register word index on the configuration port
   typedef enum logic [1:0] {
      REG_THRESHOLD = 2'd0,
      REG_ALPHA     = 2'd1,
      REG_SELECTIVE = 2'd2,
      REG_COLOR     = 2'd3
   } reg_index_type;

   // Background store write request from the merge stage
   typedef struct packed {
      logic            en;
      logic [BG_W-1:0] data;
   } wr_req_type;

   // BGR to gray, rounded, weights in Q14
   function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] b,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] r);
      logic [22:0] acc;
      acc = 23'(r) * 23'd4899 + 23'(g) * 23'd9617 + 23'(b) * 23'd1868 + 23'd8192;
      return acc[21:14];
   endfunction

endpackage

`default_nettype wire

// ===== src/bsra_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One channel: threshold compare and running-average blend
module bsra_lane (
   input  wire logic [7:0] pix,
   input  wire logic [7:0] bg,
   input  wire logic [7:0] threshold,
   input  wire logic [8:0] alpha,      // already clamped to 256
   output logic            over,
   output logic [7:0]      blend
);

   logic [7:0]  diff;
   logic [8:0]  alpha_inv;
   logic [16:0] term_new;
   logic [16:0] term_old;
   logic [8:0]  sum;

   // absolute difference against the model
   always_comb begin
      diff = (pix > bg) ? (pix - bg) : (bg - pix);
      over = (diff > threshold);
   end

   // round(a*p) + round((1-a)*b), saturated
   always_comb begin
      alpha_inv = bsra_pkg::ALPHA_ONE - alpha;
      term_new  = 17'(alpha) * 17'(pix) + 17'd128;
      term_old  = 17'(alpha_inv) * 17'(bg) + 17'd128;
      sum       = {1'b0, term_new[15:8]} + {1'b0, term_old[15:8]};
      blend     = sum[8] ? 8'hFF : sum[7:0];
   end

endmodule

`default_nettype wire

// ===== src/bsra_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Combines the lane verdicts and builds the background write
module bsra_merge (
   input  wire logic                       op,
   input  wire logic                       in_range,
   input  wire logic                       color_mode,
   input  wire logic                       selective,
   input  wire logic [2:0]                 lane_over,
   input  wire logic [2:0][7:0]            lane_blend,
   input  wire logic [2:0][7:0]            lane_pix,
   output logic                            foreground,
   output bsra_pkg::wr_req_type            wr_req
);

   logic is_load;
   logic verdict;
   logic keep_old;

   // foreground verdict: any of the three channels in color mode, gray lane otherwise
   always_comb begin
      is_load    = (op == bsra_pkg::OP_LOAD);
      verdict    = color_mode ? (|lane_over) : lane_over[0];
      foreground = in_range && !is_load && verdict;
      keep_old   = selective && foreground;
   end

   // write data: raw pixel on load, blended model on update
   always_comb begin
      wr_req.en = in_range && (is_load || !keep_old);
      if (is_load) begin
         wr_req.data = color_mode ? {lane_pix[2], lane_pix[1], lane_pix[0]}
                                  : {16'd0, lane_pix[0]};
      end else begin
         wr_req.data = color_mode ? {lane_blend[2], lane_blend[1], lane_blend[0]}
                                  : {16'd0, lane_blend[0]};
      end
   end

endmodule

`default_nettype wire

// ===== src/background_subtract_running_average.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   op, pixel_index, blue, green, red
// rsp       out        rsp_valid/rsp_stall   foreground, out_index
// csr       in/out     APB psel/penable      four registers at byte 0, 4, 8, 12
//
// One pixel per clock sustained while rsp_stall is low; rsp_valid follows the accepting
// edge through stage 1 (store read at accept), stage 2 (gray conversion) and the
// output register (lane compare/blend).
// The background store has one read port and one write port; a read-modify-write
// hazard between neighboring pixels is covered by forwarding the pending write.
// Synchronous active-high reset clears control state; the store is not cleared.
// Each stage moves forward when the next one is empty or moving, so bubbles
// collapse under rsp_stall and input is taken while a result waits.
module background_subtract_running_average #(
   parameter int PIXEL_COUNT = bsra_pkg::PIXEL_COUNT_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input transactions
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_op,
   input  wire logic [16:0] req_pixel_index,
   input  wire logic [7:0]  req_blue,
   input  wire logic [7:0]  req_green,
   input  wire logic [7:0]  req_red,
   // result transactions
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_foreground,
   output logic [16:0]      rsp_out_index,
   // configuration
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam logic [31:0] PIX_LIMIT = 32'(PIXEL_COUNT);

   // configuration registers
   logic [7:0] threshold_ff;
   logic [8:0] alpha_ff;
   logic       selective_ff;
   logic       color_ff;
   logic       csr_write;
   logic [8:0] alpha_clamped;

   // pipeline control
   logic accept;
   logic en1, en2, en_out;
   logic v1_ff, v2_ff, out_v_ff;

   // stage 1: store read in flight
   logic            s1_op_ff;
   logic [16:0]     s1_idx_ff;
   logic            s1_range_ff;
   logic [7:0]      s1_b_ff, s1_g_ff, s1_r_ff;
   logic [23:0]     rd_data_ff;
   logic            s1_hit_ff;
   logic [23:0]     s1_hit_data_ff;
   logic [23:0]     s1_bg;
   logic [7:0]      s1_gray;

   // stage 2: lanes
   logic            s2_op_ff;
   logic [16:0]     s2_idx_ff;
   logic            s2_range_ff;
   logic [2:0][7:0] s2_pix_ff;
   logic [23:0]     s2_bg_ff;

   logic [2:0]      lane_over;
   logic [2:0][7:0] lane_blend;
   logic            s2_fg;
   bsra_pkg::wr_req_type wr_req;
   logic            wr_en;

   // output register
   logic            out_fg_ff;
   logic [16:0]     out_idx_ff;

   // background store
   logic [23:0] bg_mem [PIXEL_COUNT];

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= bsra_pkg::THRESHOLD_RESET;
         alpha_ff     <= bsra_pkg::ALPHA_RESET;
         selective_ff <= bsra_pkg::SELECTIVE_RESET;
         color_ff     <= bsra_pkg::COLOR_RESET;
      end else if (csr_write) begin
         unique case (bsra_pkg::reg_index_type'(paddr[3:2]))
            bsra_pkg::REG_THRESHOLD: threshold_ff <= pwdata[7:0];
            bsra_pkg::REG_ALPHA:     alpha_ff     <= pwdata[8:0];
            bsra_pkg::REG_SELECTIVE: selective_ff <= pwdata[0];
            bsra_pkg::REG_COLOR:     color_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (bsra_pkg::reg_index_type'(paddr[3:2]))
         bsra_pkg::REG_THRESHOLD: prdata = {24'd0, threshold_ff};
         bsra_pkg::REG_ALPHA:     prdata = {23'd0, alpha_ff};
         bsra_pkg::REG_SELECTIVE: prdata = {31'd0, selective_ff};
         bsra_pkg::REG_COLOR:     prdata = {31'd0, color_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   assign alpha_clamped = (alpha_ff > bsra_pkg::ALPHA_ONE) ? bsra_pkg::ALPHA_ONE : alpha_ff;

   // ---------------- stage enables ----------------
   assign en_out    = !out_v_ff || !rsp_stall;
   assign en2       = !v2_ff || en_out;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;
   assign wr_en     = v2_ff && en_out && wr_req.en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (en1)    v1_ff    <= req_valid;
         if (en2)    v2_ff    <= v1_ff;
         if (en_out) out_v_ff <= v2_ff;
      end
   end

   // ---------------- background store ----------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bg_mem[AW'(s2_idx_ff)] <= wr_req.data;
      end
      if (accept) begin
         rd_data_ff <= bg_mem[AW'(req_pixel_index)];
      end
   end

   // ---------------- stage 1 ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= req_op;
         s1_idx_ff   <= req_pixel_index;
         s1_range_ff <= ({15'd0, req_pixel_index} < PIX_LIMIT);
         s1_b_ff     <= req_blue;
         s1_g_ff     <= req_green;
         s1_r_ff     <= req_red;
      end
   end

   // writes that land after the store read was issued
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_hit_ff <= 1'b0;
      end else if (accept) begin
         s1_hit_ff <= wr_en && (s2_idx_ff == req_pixel_index);
      end else if (wr_en && (s2_idx_ff == s1_idx_ff)) begin
         s1_hit_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept || (wr_en && (s2_idx_ff == s1_idx_ff))) begin
         s1_hit_data_ff <= wr_req.data;
      end
   end

   // newest copy of this pixel's model
   always_comb begin
      if (wr_en && (s2_idx_ff == s1_idx_ff)) begin
         s1_bg = wr_req.data;
      end else if (s1_hit_ff) begin
         s1_bg = s1_hit_data_ff;
      end else begin
         s1_bg = rd_data_ff;
      end
      s1_gray = bsra_pkg::gray_of(s1_b_ff, s1_g_ff, s1_r_ff);
   end

   // ---------------- stage 2 ----------------
   always_ff @(posedge clock) begin
      if (en2 && v1_ff) begin
         s2_op_ff     <= s1_op_ff;
         s2_idx_ff    <= s1_idx_ff;
         s2_range_ff  <= s1_range_ff;
         s2_pix_ff[0] <= color_ff ? s1_b_ff : s1_gray;
         s2_pix_ff[1] <= s1_g_ff;
         s2_pix_ff[2] <= s1_r_ff;
         s2_bg_ff     <= s1_bg;
      end
   end

   // one lane per channel; lane 0 carries gray in gray mode
   for (genvar i = 0; i < bsra_pkg::LANES; i++) begin : g_lane
      bsra_lane u_lane (
         .pix       (s2_pix_ff[i]),
         .bg        (s2_bg_ff[8*i +: 8]),
         .threshold (threshold_ff),
         .alpha     (alpha_clamped),
         .over      (lane_over[i]),
         .blend     (lane_blend[i])
      );
   end

   bsra_merge u_merge (
      .op         (s2_op_ff),
      .in_range   (s2_range_ff),
      .color_mode (color_ff),
      .selective  (selective_ff),
      .lane_over  (lane_over),
      .lane_blend (lane_blend),
      .lane_pix   (s2_pix_ff),
      .foreground (s2_fg),
      .wr_req     (wr_req)
   );

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (en_out && v2_ff) begin
         out_fg_ff  <= s2_fg;
         out_idx_ff <= s2_idx_ff;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_foreground = out_fg_ff;
   assign rsp_out_index  = out_idx_ff;

endmodule

`default_nettype wire

// ===== sim/background_subtract_running_average_tb.sv =====
`timescale 1ns / 1ps

module background_subtract_running_average_tb;
   import bsra_pkg::*;

   localparam int NPIX             = PIXEL_COUNT_DEFAULT;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_PER_PHASE = 100;

   typedef struct {
      op_type      op;
      logic [16:0] index;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
   } pixel_txn;

   typedef struct {
      logic        foreground;
      logic [16:0] index;
   } mask_txn;

   // DUT signals, all inputs known from time zero
   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic        req_op          = 1'b0;
   logic [16:0] req_pixel_index = '0;
   logic [7:0]  req_blue        = '0;
   logic [7:0]  req_green       = '0;
   logic [7:0]  req_red         = '0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic        rsp_foreground;
   logic [16:0] rsp_out_index;
   logic        psel            = 1'b0;
   logic        penable         = 1'b0;
   logic        pwrite          = 1'b0;
   logic [3:0]  paddr           = '0;
   logic [31:0] pwdata          = '0;
   logic [31:0] prdata;
   logic        pready;

   background_subtract_running_average DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_pixel_index (req_pixel_index),
      .req_blue        (req_blue),
      .req_green       (req_green),
      .req_red         (req_red),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_foreground  (rsp_foreground),
      .rsp_out_index   (rsp_out_index),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   // Pending pixels, predicted masks and the model of the background store
   pixel_txn    pixel_queue[$];
   mask_txn     mask_expect[$];
   logic [23:0] bg_model [NPIX];

   logic [7:0]  cfg_threshold = THRESHOLD_RESET;
   logic [8:0]  cfg_alpha     = ALPHA_RESET;
   logic        cfg_selective = SELECTIVE_RESET;
   logic        cfg_color     = COLOR_RESET;

   // Stimulus bookkeeping: which entries hold a background, and recent indexes
   bit [23:0]   scene [int];
   int          loaded_list[$];
   int          recent_index[$];

   int          send_idle_pct = 36;
   int          recv_idle_pct = 84;
   bit          req_taken     = 1'b0;
   int          error_count   = 0;
   int          cycle_count   = 0;
   int          pixels_sent   = 0;
   int          masks_seen    = 0;
   int          fg_seen       = 0;
   int          phase_count   = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Gray conversion with Q14 weights, rounded
   function automatic logic [7:0] luma(logic [7:0] b, logic [7:0] g, logic [7:0] r);
      int unsigned acc;
      acc = int'(r) * 4899 + int'(g) * 9617 + int'(b) * 1868 + 8192;
      return 8'(acc >> 14);
   endfunction

   function automatic logic [7:0] absdiff(logic [7:0] x, logic [7:0] y);
      return (x > y) ? x - y : y - x;
   endfunction

   // Running average of one channel, alpha clamped to one, sum saturated
   function automatic logic [7:0] mix_channel(logic [7:0] p, logic [7:0] b);
      int unsigned a;
      int unsigned s;
      a = (cfg_alpha > ALPHA_ONE) ? 256 : int'(cfg_alpha);
      s = ((a * p + 128) >> 8) + (((256 - a) * b + 128) >> 8);
      return (s > 255) ? 8'd255 : 8'(s);
   endfunction

   // Predicts the mask bit of one pixel and updates the background model
   function automatic logic classify_pixel(pixel_txn t);
      logic [23:0] old;
      logic [7:0]  bg_b;
      logic [7:0]  bg_g;
      logic [7:0]  bg_r;
      logic [7:0]  gy;
      logic        fg;
      fg = 1'b0;
      if (int'(t.index) < NPIX) begin
         old  = bg_model[t.index];
         bg_b = old[7:0];
         bg_g = old[15:8];
         bg_r = old[23:16];
         if (t.op == OP_LOAD) begin
            if (cfg_color)
               bg_model[t.index] = {t.red, t.green, t.blue};
            else
               bg_model[t.index] = {16'd0, luma(t.blue, t.green, t.red)};
         end else if (cfg_color) begin
            fg = (absdiff(t.blue, bg_b) > cfg_threshold) ||
                 (absdiff(t.green, bg_g) > cfg_threshold) ||
                 (absdiff(t.red, bg_r) > cfg_threshold);
            if (!(cfg_selective && fg))
               bg_model[t.index] = {mix_channel(t.red, bg_r), mix_channel(t.green, bg_g),
                                    mix_channel(t.blue, bg_b)};
         end else begin
            gy = luma(t.blue, t.green, t.red);
            fg = absdiff(gy, bg_b) > cfg_threshold;
            if (!(cfg_selective && fg))
               bg_model[t.index] = {16'd0, mix_channel(gy, bg_b)};
         end
      end
      return fg;
   endfunction

   function automatic void queue_item(op_type op, int index, int b, int g, int r);
      pixel_txn t;
      t.op    = op;
      t.index = 17'(index);
      t.blue  = 8'(b);
      t.green = 8'(g);
      t.red   = 8'(r);
      pixel_queue = {pixel_queue, t};
      if (op == OP_LOAD) begin
         if (!scene.exists(index))
            loaded_list = {loaded_list, index};
         scene[index] = {t.red, t.green, t.blue};
      end
      recent_index = {recent_index, index};
      if (recent_index.size() > 4)
         void'(recent_index.pop_front());
   endfunction

   function automatic int jitter(int v);
      int x;
      x = v + int'($urandom_range(0, 80)) - 40;
      return (x < 0) ? 0 : (x > 255) ? 255 : x;
   endfunction

   // Mostly segments of loaded entries, half of them near their scene, heavy reuse of recent
   // indexes so that back-to-back updates of one entry are common
   function automatic void queue_random_item();
      int        index;
      int        pick;
      int        style;
      bit [23:0] base;
      pick = $urandom_range(0, 99);
      if (loaded_list.size() == 0 || pick < 20) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)
            index = ($urandom_range(0, 1) ? NPIX - 8 : 0) + int'($urandom_range(0, 7));
         else
            index = $urandom_range(0, NPIX - 1);
         queue_item(OP_LOAD, index, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 255));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            index = recent_index[$urandom_range(0, recent_index.size() - 1)];
         else
            index = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
         base  = scene[index];
         style = $urandom_range(0, 3);
         case (style)
            0, 1: begin
               queue_item(OP_SEGMENT, index, jitter(int'(base[7:0])), jitter(int'(base[15:8])),
                          jitter(int'(base[23:16])));
            end
            2: begin
               queue_item(OP_SEGMENT, index, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            end
            default: begin
               queue_item(OP_SEGMENT, index, $urandom_range(0, 1) * 255,
                          $urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255);
            end
         endcase
      end
   endfunction

   // Driver: next pixel once the current transaction is taken, random idle cycles;
   // the receiver stall is drawn here as well
   always @(negedge clock) begin : drive_block
      pixel_txn t;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            t = pixel_queue.pop_front();
            req_valid       <= 1'b1;
            req_op          <= t.op;
            req_pixel_index <= t.index;
            req_blue        <= t.blue;
            req_green       <= t.green;
            req_red         <= t.red;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // Monitor: predict on accepted pixels, check accepted masks in order
   always @(posedge clock) begin : check_block
      pixel_txn t;
      mask_txn  m;
      mask_txn  want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            req_taken    = 1'b1;
            t.op         = op_type'(req_op);
            t.index      = req_pixel_index;
            t.blue       = req_blue;
            t.green      = req_green;
            t.red        = req_red;
            m.foreground = classify_pixel(t);
            m.index      = req_pixel_index;
            mask_expect  = {mask_expect, m};
            pixels_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            masks_seen++;
            if (mask_expect.size() == 0) begin
               $error("unexpected result transaction: out_index %0d", rsp_out_index);
               error_count++;
            end else begin
               want = mask_expect.pop_front();
               if (rsp_foreground) fg_seen++;
               if (rsp_foreground !== want.foreground) begin
                  $error("foreground mismatch: expected %0d, actual %0d",
                         want.foreground, rsp_foreground);
                  error_count++;
               end
               if (rsp_out_index !== want.index) begin
                  $error("out_index mismatch: expected %0d, actual %0d",
                         want.index, rsp_out_index);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic csr_write(reg_index_type r, logic [31:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {r, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (r)
         REG_THRESHOLD: cfg_threshold = value[7:0];
         REG_ALPHA:     cfg_alpha     = value[8:0];
         REG_SELECTIVE: cfg_selective = value[0];
         default:       cfg_color     = value[0];
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_expect(reg_index_type r, logic [31:0] want, logic [31:0] mask);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {r, 2'b00};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if ((prdata & mask) !== want) begin
         $error("%s readback mismatch: expected %0d, actual %0d", r.name(), want,
                prdata & mask);
         error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic apply_setting(int thr, int alpha, int sel, int color);
      csr_write(REG_THRESHOLD, thr);
      csr_write(REG_ALPHA, alpha);
      csr_write(REG_SELECTIVE, sel);
      csr_write(REG_COLOR, color);
      csr_expect(REG_THRESHOLD, thr, 32'h0FF);
      csr_expect(REG_ALPHA, alpha, 32'h1FF);
      csr_expect(REG_SELECTIVE, sel, 32'h1);
      csr_expect(REG_COLOR, color, 32'h1);
      phase_count++;
   endtask

   // Sender holds off until every predicted mask has come back
   task automatic wait_drained();
      while (pixel_queue.size() != 0 || req_valid || mask_expect.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_random_phase(int thr, int alpha, int sel, int color,
                                   int sidle, int ridle);
      apply_setting(thr, alpha, sel, color);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      repeat (RANDOM_PER_PHASE) queue_random_item();
      wait_drained();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers come out of reset at their defaults
      csr_expect(REG_THRESHOLD, 32'(THRESHOLD_RESET), 32'h0FF);
      csr_expect(REG_ALPHA, 32'(ALPHA_RESET), 32'h1FF);
      csr_expect(REG_SELECTIVE, 32'(SELECTIVE_RESET), 32'h1);
      csr_expect(REG_COLOR, 32'(COLOR_RESET), 32'h1);

      // Directed, gray mode at reset settings
      queue_item(OP_LOAD, 0, 0, 0, 0);
      queue_item(OP_LOAD, NPIX - 1, 255, 255, 255);
      queue_item(OP_LOAD, 1, 100, 100, 100);
      queue_item(OP_LOAD, 3, 100, 100, 100);
      queue_item(OP_LOAD, 2, 100, 100, 100);
      queue_item(OP_SEGMENT, 0, 0, 0, 0);
      queue_item(OP_SEGMENT, 0, 255, 255, 255);        // foreground, kept by selective
      queue_item(OP_SEGMENT, NPIX - 1, 255, 255, 255); // blend stays at 255
      queue_item(OP_SEGMENT, NPIX - 1, 0, 0, 0);
      queue_item(OP_SEGMENT, 2, 130, 130, 130);        // difference equal to threshold
      queue_item(OP_SEGMENT, 3, 131, 131, 131);        // one above threshold
      queue_item(OP_SEGMENT, 1, 120, 120, 120);        // same entry back to back
      queue_item(OP_SEGMENT, 1, 120, 120, 120);
      queue_item(OP_SEGMENT, 1, 120, 120, 120);
      queue_item(OP_SEGMENT, 1, 95, 110, 140);
      queue_item(OP_SEGMENT, 0, 10, 200, 40);
      queue_item(OP_SEGMENT, 1, 200, 10, 40);
      queue_item(OP_SEGMENT, 0, 0, 0, 30);
      wait_drained();

      // Directed, color mode; entry 0 still holds a gray background
      apply_setting(int'(THRESHOLD_RESET), int'(ALPHA_RESET), int'(SELECTIVE_RESET), 1);
      queue_item(OP_LOAD, 4, 0, 128, 255);
      queue_item(OP_SEGMENT, 4, 31, 128, 255);
      queue_item(OP_SEGMENT, 4, 0, 128, 255);
      queue_item(OP_SEGMENT, 0, 5, 5, 5);
      queue_item(OP_SEGMENT, NPIX - 1, 255, 255, 255);
      wait_drained();

      // Random phases: receiver idles most first, then the sender, then neither
      run_random_phase(int'(THRESHOLD_RESET), int'(ALPHA_RESET), int'(SELECTIVE_RESET),
                       int'(COLOR_RESET), 36, 84);
      run_random_phase(0, 256, 0, 1, 36, 84);
      run_random_phase(255, 0, 1, 1, 36, 84);
      run_random_phase(8, 128, 0, 0, 84, 36);
      run_random_phase(255, 256, 1, 0, 84, 36);
      run_random_phase(0, 0, 0, 1, 84, 36);
      run_random_phase($urandom_range(0, 255), $urandom_range(0, 256), $urandom_range(0, 1),
                       $urandom_range(0, 1), 0, 0);
      run_random_phase(40, 200, 1, 1, 0, 0);

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Run covered %0d pixel transactions over %0d register settings", pixels_sent,
               phase_count);
      $display("(gray and color, selective on and off, alpha 0..256): %0d masks, %0d foreground",
               masks_seen, fg_seen);
      if (error_count == 0 && mask_expect.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== background_subtract_running_average.f =====
src/bsra_pkg.sv
src/bsra_lane.sv
src/bsra_merge.sv
src/background_subtract_running_average.sv
sim/background_subtract_running_average_tb.sv
